// File: hdl/tprs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tprs_pkg: shared types and constants for the track point radius search unit
// Field widths, register codes and reset values, the input and result words,
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tprs_pkg;

	// fixed field widths
	localparam int IDX_W      = 13;
	localparam int COORD_W    = 24;
	localparam int CNT_W      = 14;
	localparam int TOL_W      = 16;
	localparam int AXIS_W     = 16;
	localparam int SQ_W       = 2 * AXIS_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int TOL_SQ_W   = 2 * TOL_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MOD_CNT_W  = $clog2(IDX_W);

	// parameter defaults
	localparam int MAX_POINTS_DEF = 8192;
	localparam int COORD_BITS_DEF = 24;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_TOL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PIT_TOL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PIT_ENTRY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PIT_EXIT    = 3'd4;

	// register reset values
	localparam logic [CNT_W-1:0] POINT_COUNT_RST = '0;
	localparam logic [TOL_W-1:0] TOLERANCE_RST   = 16'd480;
	localparam logic [IDX_W-1:0] PIT_INDEX_RST   = '0;

	// function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// input word
	typedef struct packed {
		logic                      func;
		logic [IDX_W-1:0]          load_index;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [IDX_W-1:0]          start_offset;
	} point_cmd_t;

	// result word
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] match_index;
	} match_res_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic mod_step;
		logic mem_write;
		logic scan_init;
		logic scan_issue;
		logic scan_active;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_query;
		logic n_zero;
		logic mod_last;
		logic issue_last;
		logic hit;
		logic pipe_empty;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: hdl/tprs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tprs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tprs_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/tprs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tprs_ctrl: sequencer for the radius search
// Walks each word through the modulo steps, then a table write or a scan,
// and raises the result strobe when the scan ends, or without a scan for a query on an empty table.
// ----------------------------------------------------------------------------
module tprs_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	output logic                     done,
	input  wire tprs_pkg::dp_stat_t  stat,
	output tprs_pkg::ctrl_cmd_t      ctl
);
	import tprs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_DECIDE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	assign busy = busy_q;
	assign done = done_q;

	// decode commands from state
	always_comb begin
		ctl             = '0;
		ctl.capture     = (state_q == ST_IDLE) && start;
		ctl.mod_step    = (state_q == ST_MOD);
		ctl.mem_write   = (state_q == ST_DECIDE) && !stat.is_query;
		ctl.scan_init   = (state_q == ST_DECIDE) && stat.is_query && !stat.n_zero;
		ctl.scan_issue  = (state_q == ST_SCAN);
		ctl.scan_active = (state_q == ST_SCAN) || (state_q == ST_DRAIN);
	end

	// advance state, hold busy and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						busy_q  <= 1'b1;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (stat.mod_last) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!stat.is_query) begin
						busy_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else if (stat.n_zero) begin
						done_q  <= 1'b1;
						busy_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.hit) begin
						done_q  <= 1'b1;
						busy_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else if (stat.issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (stat.hit || stat.pipe_empty) begin
						done_q  <= 1'b1;
						busy_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// result is given only once the word is finished
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	// accepted word makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

endmodule
`default_nettype wire

// File: hdl/tprs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tprs_dp: datapath of the radius search
// Configuration registers, shared bit-serial modulo unit, scan address
// counter, point table and a three-stage distance and tolerance pipeline.
// ----------------------------------------------------------------------------
module tprs_dp #(
	parameter int MAX_POINTS = tprs_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = tprs_pkg::COORD_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire tprs_pkg::point_cmd_t                 cmd,
	input  wire logic                                 wr_en,
	input  wire logic [tprs_pkg::CFG_IDX_W-1:0]       wr_index,
	input  wire logic [tprs_pkg::CFG_DATA_W-1:0]      wr_data,
	input  wire tprs_pkg::ctrl_cmd_t                  ctl,
	output tprs_pkg::dp_stat_t                        stat,
	output tprs_pkg::match_res_t                      result
);
	import tprs_pkg::*;

	localparam int A_W     = $clog2(MAX_POINTS);
	localparam int N_W     = $clog2(MAX_POINTS + 1);
	localparam int R_W     = N_W + 1;
	localparam int D_W     = COORD_BITS + 1;
	localparam int AD_W    = (D_W > AXIS_W + 1) ? D_W : AXIS_W + 1;
	localparam int CMP_W   = (A_W > IDX_W) ? A_W : IDX_W;
	localparam int MEM_W   = 3 * COORD_BITS;

	// configuration registers
	logic [CNT_W-1:0]    point_count_q;
	logic [TOL_W-1:0]    normal_tol_q;
	logic [TOL_W-1:0]    pit_tol_q;
	logic [IDX_W-1:0]    pit_entry_q;
	logic [IDX_W-1:0]    pit_exit_q;
	logic [TOL_SQ_W-1:0] normal_sq_q;
	logic [TOL_SQ_W-1:0] pit_sq_q;

	// captured word
	logic                  func_q;
	logic [2:0][COORD_BITS-1:0] pos_q;
	logic [N_W-1:0]        n_q;
	logic [N_W-1:0]        n_clamp;

	// modulo unit
	logic [IDX_W-1:0]      num_q;
	logic [N_W-1:0]        div_q;
	logic [N_W-1:0]        rem_q;
	logic [MOD_CNT_W-1:0]  mod_cnt_q;
	logic [R_W-1:0]        trial;
	logic [R_W-1:0]        trial_sub;

	// scan counter
	logic [A_W-1:0]        addr_q;
	logic [N_W-1:0]        addr_inc;
	logic [N_W-1:0]        cnt_q;

	// table
	logic [MEM_W-1:0]      rdata;

	// pipeline
	logic                  v_rd_q;
	logic [A_W-1:0]        idx_rd_q;
	logic                  v_s1;
	logic [A_W-1:0]        idx_s1;
	logic [2:0][AXIS_W-1:0] abs_s1;
	logic                  ovf_s1;
	logic                  pit_s1;
	logic                  v_s2;
	logic [A_W-1:0]        idx_s2;
	logic [2:0][SQ_W-1:0]  sq_s2;
	logic                  ovf_s2;
	logic                  pit_s2;
	logic                  v_s3;
	logic [A_W-1:0]        idx_s3;
	logic                  match_s3;
	logic [2:0][AXIS_W-1:0] abs_d;
	logic                  ovf_d;
	logic                  pit_d;
	logic [CMP_W-1:0]      cmp_i;
	logic [CMP_W-1:0]      cmp_en;
	logic [CMP_W-1:0]      cmp_ex;
	logic [SUM_W-1:0]      sum_d;

	match_res_t            res_q;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= POINT_COUNT_RST;
			normal_tol_q  <= TOLERANCE_RST;
			pit_tol_q     <= TOLERANCE_RST;
			pit_entry_q   <= PIT_INDEX_RST;
			pit_exit_q    <= PIT_INDEX_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_POINT_COUNT: point_count_q <= wr_data[CNT_W-1:0];
				CFG_NORMAL_TOL:  normal_tol_q  <= wr_data[TOL_W-1:0];
				CFG_PIT_TOL:     pit_tol_q     <= wr_data[TOL_W-1:0];
				CFG_PIT_ENTRY:   pit_entry_q   <= wr_data[IDX_W-1:0];
				CFG_PIT_EXIT:    pit_exit_q    <= wr_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// square the tolerances once configured
	always_ff @(posedge clk) begin
		normal_sq_q <= TOL_SQ_W'(normal_tol_q) * TOL_SQ_W'(normal_tol_q);
		pit_sq_q    <= TOL_SQ_W'(pit_tol_q) * TOL_SQ_W'(pit_tol_q);
	end

	// clamp point count to table depth
	assign n_clamp = (32'(point_count_q) > MAX_POINTS) ? N_W'(MAX_POINTS)
	                                                   : N_W'(point_count_q);

	// restoring remainder step: one dividend bit per cycle
	assign trial     = {rem_q, num_q[IDX_W-1]};
	assign trial_sub = trial - R_W'(div_q);

	// capture word, run modulo unit
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			func_q    <= cmd.func;
			pos_q[2]  <= COORD_BITS'(cmd.pos_x);
			pos_q[1]  <= COORD_BITS'(cmd.pos_y);
			pos_q[0]  <= COORD_BITS'(cmd.pos_z);
			n_q       <= n_clamp;
			num_q     <= (cmd.func == FUNC_QUERY) ? cmd.start_offset : cmd.load_index;
			div_q     <= (cmd.func == FUNC_QUERY) ? n_clamp : N_W'(MAX_POINTS);
			rem_q     <= '0;
			mod_cnt_q <= '0;
		end else if (ctl.mod_step) begin
			num_q     <= {num_q[IDX_W-2:0], 1'b0};
			rem_q     <= (trial >= R_W'(div_q)) ? N_W'(trial_sub) : N_W'(trial);
			mod_cnt_q <= mod_cnt_q + 1'b1;
		end
	end

	// advance scan address with wrap at point count
	assign addr_inc = N_W'(addr_q) + N_W'(1);

	always_ff @(posedge clk) begin
		if (ctl.scan_init) begin
			addr_q <= rem_q[A_W-1:0];
			cnt_q  <= n_q;
		end else if (ctl.scan_issue) begin
			addr_q <= (addr_inc == n_q) ? '0 : addr_inc[A_W-1:0];
			cnt_q  <= cnt_q - 1'b1;
		end
	end

	// point table
	tprs_ram #(
		.WIDTH (MEM_W),
		.DEPTH (MAX_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (ctl.mem_write),
		.waddr (rem_q[A_W-1:0]),
		.wdata (pos_q),
		.re    (ctl.scan_issue),
		.raddr (addr_q),
		.rdata (rdata)
	);

	// axis differences, magnitude and range check
	always_comb begin
		logic [D_W-1:0]  d;
		logic [D_W-1:0]  ad;
		logic [AD_W-1:0] ad_ext;
		logic [COORD_BITS-1:0] rc;
		ovf_d = 1'b0;
		for (int a = 0; a < 3; a++) begin
			rc       = rdata[a*COORD_BITS +: COORD_BITS];
			d        = {pos_q[a][COORD_BITS-1], pos_q[a]} - {rc[COORD_BITS-1], rc};
			ad       = d[D_W-1] ? (~d + 1'b1) : d;
			ad_ext   = AD_W'(ad);
			abs_d[a] = ad_ext[AXIS_W-1:0];
			ovf_d    = ovf_d | (|ad_ext[AD_W-1:AXIS_W]);
		end
	end

	// pit zone, exclusive at both ends, wraps when entry above exit
	assign cmp_i  = CMP_W'(idx_rd_q);
	assign cmp_en = CMP_W'(pit_entry_q);
	assign cmp_ex = CMP_W'(pit_exit_q);

	always_comb begin
		if (cmp_en > cmp_ex) begin
			pit_d = (cmp_i < cmp_ex) || (cmp_i > cmp_en);
		end else if (cmp_en < cmp_ex) begin
			pit_d = (cmp_i < cmp_ex) && (cmp_i > cmp_en);
		end else begin
			pit_d = 1'b0;
		end
	end

	assign sum_d = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);

	// pipeline valids, dropped outside a scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_rd_q <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else begin
			v_rd_q <= ctl.scan_issue;
			v_s1   <= ctl.scan_active && v_rd_q;
			v_s2   <= ctl.scan_active && v_s1;
			v_s3   <= ctl.scan_active && v_s2;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		idx_rd_q <= addr_q;
		idx_s1   <= idx_rd_q;
		abs_s1   <= abs_d;
		ovf_s1   <= ovf_d;
		pit_s1   <= pit_d;
		idx_s2   <= idx_s1;
		ovf_s2   <= ovf_s1;
		pit_s2   <= pit_s1;
		for (int a = 0; a < 3; a++) begin
			sq_s2[a] <= SQ_W'(abs_s1[a]) * SQ_W'(abs_s1[a]);
		end
		idx_s3   <= idx_s2;
		match_s3 <= !ovf_s2 &&
		            (sum_d <= SUM_W'(pit_s2 ? pit_sq_q : normal_sq_q));
	end

	// hold result, clear on a new word, take the first hit
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			res_q <= '0;
		end else if (ctl.scan_active && stat.hit) begin
			res_q.found       <= 1'b1;
			res_q.match_index <= IDX_W'(idx_s3);
		end
	end

	assign result = res_q;

	// status back to controller
	always_comb begin
		stat            = '0;
		stat.is_query   = (func_q == FUNC_QUERY);
		stat.n_zero     = (n_q == '0);
		stat.mod_last   = (mod_cnt_q == MOD_CNT_W'(IDX_W - 1));
		stat.issue_last = (cnt_q == N_W'(1));
		stat.hit        = v_s3 && match_s3;
		stat.pipe_empty = !(v_rd_q || v_s1 || v_s2 || v_s3);
	end

	// scan address stays inside the valid table
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_issue |-> (N_W'(addr_q) < n_q))
		else $error("scan address beyond point count");

	// start offset remainder is below the point count
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_init |-> (rem_q < n_q))
		else $error("scan start remainder not reduced");

endmodule
`default_nettype wire

// File: hdl/track_point_radius_search_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// track_point_radius_search_unit: first-match reference point search, top level
// Holds a table of 3D reference points and finds the first point within a
// zone-dependent radius of a query position, scanning circularly.
// ----------------------------------------------------------------------------
// Raise start with a word on cmd while busy is low; the word is taken at that
// edge and busy stays high until it is finished. A load word (func 0) writes
// one point: 13 modulo steps for the slot, then the table write. A query word
// (func 1) takes 13 modulo steps for the scan start, a setup state, then reads
// one table entry per cycle through the single read port of the point RAM; the
// entry's distance check leaves a four-stage pipeline. A query with no match
// reads all point_count entries (at most the table depth) and gives its
// result as busy falls, one with a hit ends when the matching entry leaves the
// pipeline, and an empty table answers after the modulo steps, with no scan.
// Each query gives exactly one result word: done is high for one cycle with
// result valid, and the receiver must take it then. Loads give no result.
// Write configuration only while busy is low.
// ----------------------------------------------------------------------------
module track_point_radius_search_unit #(
	parameter int MAX_POINTS = tprs_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = tprs_pkg::COORD_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire tprs_pkg::point_cmd_t            cmd,
	output logic                                 done,
	output tprs_pkg::match_res_t                 result,
	input  wire logic                            wr_en,
	input  wire logic [tprs_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [tprs_pkg::CFG_DATA_W-1:0] wr_data
);
	import tprs_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	// sequencer
	tprs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.ctl    (ctl)
	);

	// datapath
	tprs_dp #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.ctl      (ctl),
		.stat     (stat),
		.result   (result)
	);

endmodule
`default_nettype wire

// File: test/tprs_match_checker.sv
// ----------------------------------------------------------------------------
// tprs_match_checker: result checker for the track point radius search unit
// Watches the command, configuration and result channels. Keeps its own copy
// of the point table and registers, works out the answer of every accepted
// query, and compares each result word against the oldest open answer.
// ----------------------------------------------------------------------------
module tprs_match_checker #(
	parameter int MAX_POINTS = tprs_pkg::MAX_POINTS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic                            busy,
	input  wire tprs_pkg::point_cmd_t            cmd,
	input  wire logic                            done,
	input  wire tprs_pkg::match_res_t            result,
	input  wire logic                            wr_en,
	input  wire logic [tprs_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [tprs_pkg::CFG_DATA_W-1:0] wr_data,
	output int                                   failures,
	output int                                   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import tprs_pkg::*;

	// largest per-axis distance that can still fall inside a 16-bit radius
	localparam longint AXIS_REACH = (longint'(1) << AXIS_W) - 1;

	// mirrored table and registers
	logic signed [COORD_W-1:0] stored_x [MAX_POINTS];
	logic signed [COORD_W-1:0] stored_y [MAX_POINTS];
	logic signed [COORD_W-1:0] stored_z [MAX_POINTS];
	logic [CNT_W-1:0] point_cnt;
	logic [TOL_W-1:0] tol_normal;
	logic [TOL_W-1:0] tol_pit;
	logic [IDX_W-1:0] pit_entry;
	logic [IDX_W-1:0] pit_exit;

	match_res_t open_matches [$];
	match_res_t want;

	initial failures = 0;

	task automatic report(input string what);
		$display("%0t ns  mismatch: %s", $time, what);
		failures++;
	endtask

	// squared distance on one axis, or -1 when the axis alone is out of reach
	function automatic longint axis_sq(input logic signed [COORD_W-1:0] a,
			input logic signed [COORD_W-1:0] b);
		longint d;
		d = a;
		d = d - b;
		if (d < 0)
			d = -d;
		return (d > AXIS_REACH) ? -1 : d * d;
	endfunction

	// pit zone bounds are both exclusive; entry above exit wraps the zone
	function automatic bit in_pit_zone(input int unsigned i);
		if (pit_entry > pit_exit)
			return i < pit_exit || i > pit_entry;
		if (pit_entry < pit_exit)
			return i > pit_entry && i < pit_exit;
		return 1'b0;
	endfunction

	// circular scan for the first stored point within its zone's radius
	function automatic match_res_t scan_for_match(input point_cmd_t q);
		match_res_t r;
		int unsigned n;
		int unsigned first;
		int unsigned idx;
		longint sx;
		longint sy;
		longint sz;
		longint radius;
		r = '0;
		n = point_cnt;
		if (n > MAX_POINTS)
			n = MAX_POINTS;
		if (n == 0)
			return r;
		first = q.start_offset % n;
		for (int unsigned j = 0; j < n; j++) begin
			idx = first + j;
			if (idx >= n)
				idx -= n;
			sx = axis_sq(q.pos_x, stored_x[idx]);
			sy = axis_sq(q.pos_y, stored_y[idx]);
			sz = axis_sq(q.pos_z, stored_z[idx]);
			if (sx >= 0 && sy >= 0 && sz >= 0) begin
				radius = in_pit_zone(idx) ? tol_pit : tol_normal;
				if (sx + sy + sz <= radius * radius) begin
					r.found = 1'b1;
					r.match_index = IDX_W'(idx);
					return r;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_cnt = POINT_COUNT_RST;
			tol_normal = TOLERANCE_RST;
			tol_pit = TOLERANCE_RST;
			pit_entry = PIT_INDEX_RST;
			pit_exit = PIT_INDEX_RST;
			open_matches.delete();
			pending <= 0;
		end else begin
			// retire a result word against the oldest open answer
			if (done) begin
				if (open_matches.size() == 0) begin
					report($sformatf("result word (found %b, index %0d) with no query open",
						result.found, result.match_index));
				end else begin
					want = open_matches.pop_front();
					if (result.found !== want.found)
						report($sformatf("found: got %b, want %b", result.found, want.found));
					if (result.match_index !== want.match_index)
						report($sformatf("match_index: got %0d, want %0d",
							result.match_index, want.match_index));
				end
			end

			// track register writes; unknown indexes fall through
			if (wr_en) begin
				case (wr_index)
					CFG_POINT_COUNT: point_cnt = wr_data[CNT_W-1:0];
					CFG_NORMAL_TOL:  tol_normal = wr_data[TOL_W-1:0];
					CFG_PIT_TOL:     tol_pit = wr_data[TOL_W-1:0];
					CFG_PIT_ENTRY:   pit_entry = wr_data[IDX_W-1:0];
					CFG_PIT_EXIT:    pit_exit = wr_data[IDX_W-1:0];
					default: ;
				endcase
			end

			// accepted word: store a point or open an answer
			if (start && !busy) begin
				if (cmd.func == FUNC_LOAD) begin
					stored_x[cmd.load_index % MAX_POINTS] = cmd.pos_x;
					stored_y[cmd.load_index % MAX_POINTS] = cmd.pos_y;
					stored_z[cmd.load_index % MAX_POINTS] = cmd.pos_z;
				end else begin
					open_matches.push_back(scan_for_match(cmd));
				end
			end

			pending <= open_matches.size();
		end
	end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the track point radius search unit
// Loads point tables, programs radii and pit zones between phases, and sends
// directed and random load and query words with random gaps. A checker beside
// the block predicts every query answer and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tprs_pkg::*;

	// register indexes the block does not decode
	localparam int CFG_SPARE_FIRST = 5;
	localparam int CFG_SPARE_LAST  = 7;

	localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
	localparam int COORD_MIN = -(1 << (COORD_W - 1));

	// slots of the small directed table
	localparam int SMALL_SLOTS = 6;

	// low slots hold a tight cluster around the origin so random queries hit
	localparam int CLUSTER_SLOTS = 16;
	localparam int CLUSTER_SPAN  = 1500;

	// two far landmarks in the upper half of the table
	localparam int MARK_A_SLOT = MAX_POINTS_DEF - 1;
	localparam int MARK_A_X = 4000000, MARK_A_Y = -4000000, MARK_A_Z = 123456;
	localparam int MARK_B_SLOT = MAX_POINTS_DEF / 2;
	localparam int MARK_B_X = -3000000, MARK_B_Y = 2500000, MARK_B_Z = -6000000;

	localparam int SETTLE_CYCLES = 24;
	localparam int TAIL_CYCLES   = 40;
	localparam int EPOCHS        = 6;
	localparam int EPOCH_WORDS   = 10;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	point_cmd_t cmd;
	logic done;
	match_res_t result;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	int failures;
	int pending;
	bit steady;

	track_point_radius_search_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	tprs_match_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.failures (failures),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#25_000_000;
		$display("track_point_radius_search_unit test failed");
		$finish;
	end

	// send one word: optional idle gap, then hold start until taken
	task automatic issue(input point_cmd_t w);
		int gap;
		bit idle_first;
		gap = steady ? 0 : $urandom_range(0, 9);
		idle_first = !steady && ($urandom_range(0, 1) == 1);
		if (gap > 0 || idle_first) begin
			start <= 1'b0;
			if (idle_first) begin
				@(posedge clk);
				while (busy) @(posedge clk);
			end
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic load_point(input int slot, input int x, input int y, input int z);
		point_cmd_t w;
		w.func = FUNC_LOAD;
		w.load_index = slot[IDX_W-1:0];
		w.pos_x = x[COORD_W-1:0];
		w.pos_y = y[COORD_W-1:0];
		w.pos_z = z[COORD_W-1:0];
		w.start_offset = IDX_W'($urandom());
		issue(w);
	endtask

	task automatic query(input int x, input int y, input int z, input int offset);
		point_cmd_t w;
		w.func = FUNC_QUERY;
		w.load_index = IDX_W'($urandom());
		w.pos_x = x[COORD_W-1:0];
		w.pos_y = y[COORD_W-1:0];
		w.pos_z = z[COORD_W-1:0];
		w.start_offset = offset[IDX_W-1:0];
		issue(w);
	endtask

	// drop start and wait until every answer is back and the block is idle
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] count,
			input logic [CFG_DATA_W-1:0] normal, input logic [CFG_DATA_W-1:0] pit,
			input logic [CFG_DATA_W-1:0] entry, input logic [CFG_DATA_W-1:0] pit_out);
		settle();
		write_reg(CFG_POINT_COUNT, count);
		write_reg(CFG_NORMAL_TOL, normal);
		write_reg(CFG_PIT_TOL, pit);
		write_reg(CFG_PIT_ENTRY, entry);
		write_reg(CFG_PIT_EXIT, pit_out);
	endtask

	function automatic int near_coord();
		return int'($urandom_range(0, 2 * CLUSTER_SPAN)) - CLUSTER_SPAN;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] draw_radius();
		if ($urandom_range(0, 2) != 0)
			return CFG_DATA_W'($urandom_range(0, 2 * CLUSTER_SPAN));
		return CFG_DATA_W'($urandom_range(0, 65535));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] draw_pit_bound();
		if ($urandom_range(0, 1) == 1)
			return CFG_DATA_W'($urandom_range(0, CLUSTER_SLOTS + 1));
		return CFG_DATA_W'($urandom_range(0, MAX_POINTS_DEF - 1));
	endfunction

	// one random word: mostly cluster queries, some cluster loads, some noise
	task automatic random_word();
		point_cmd_t w;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			load_point($urandom_range(0, CLUSTER_SLOTS - 1), near_coord(), near_coord(),
				near_coord());
		end else if (pick < 30) begin
			w.func = 1'($urandom_range(0, 1));
			w.load_index = IDX_W'($urandom());
			w.pos_x = COORD_W'($urandom());
			w.pos_y = COORD_W'($urandom());
			w.pos_z = COORD_W'($urandom());
			w.start_offset = IDX_W'($urandom());
			issue(w);
		end else begin
			query(near_coord(), near_coord(), near_coord(), $urandom());
		end
	endtask

	initial begin
		int count;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		steady = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table straight out of reset
		query(COORD_MAX, COORD_MIN, 0, 8191);

		// small table: origin, both coordinate extremes, a boundary pair, far x
		load_point(0, 0, 0, 0);
		load_point(1, COORD_MAX, COORD_MAX, COORD_MAX);
		load_point(2, COORD_MIN, COORD_MIN, COORD_MIN);
		load_point(3, 1000, -2000, 3000);
		load_point(4, 1480, -2000, 3000);
		load_point(5, -32768, 0, 0);

		configure(6, 480, 480, 0, 0);
		query(COORD_MAX, COORD_MAX, COORD_MAX, 0);
		query(COORD_MIN, COORD_MIN, COORD_MIN, 3);
		query(1480, -2000, 3000, 4);
		query(1480, -2000, 3000, 3);
		query(1481, -2000, 3000, 3);
		query(-1, -1, -1, 5);
		query(5000000, 0, 0, 8191);

		// widest radius: axis distance right at and just past the reach
		configure(6, 65535, 480, 0, 0);
		query(32767, 0, 0, 5);
		query(32768, 0, 40000, 5);

		// plain pit zone with zero pit radius
		configure(6, 480, 0, 2, 5);
		query(1480, -2000, 3000, 3);
		query(1000, -2000, 3000, 3);

		// wrapping pit zone, both radii zero
		configure(6, 0, 0, 4, 1);
		query(-1, -1, -1, 0);
		query(0, 0, 0, 0);

		// equal bounds mean no pit zone
		configure(6, 480, 0, 9, 9);
		query(-1, -1, -1, 0);

		// grow the cluster above the small table, then place the landmarks
		for (int slot = SMALL_SLOTS; slot < CLUSTER_SLOTS; slot++)
			load_point(slot, near_coord(), near_coord(), near_coord());
		load_point(MARK_A_SLOT, MARK_A_X, MARK_A_Y, MARK_A_Z);
		load_point(MARK_B_SLOT, MARK_B_X, MARK_B_Y, MARK_B_Z);

		// oversized count clamps to the full table; each scan here hits
		// before it can reach a slot that was never loaded
		configure(16'hFFFF, 480, 480, 8000, 100);
		query(MARK_A_X, MARK_A_Y, MARK_A_Z, MARK_A_SLOT);
		query(MARK_B_X + 100, MARK_B_Y, MARK_B_Z, MARK_B_SLOT);
		// miss at the last slot, wrap to the origin at slot 0
		query(-1, -1, -1, MARK_A_SLOT);

		configure(CFG_DATA_W'(MAX_POINTS_DEF), 480, 480, 0, 0);
		query(MARK_A_X, MARK_A_Y, MARK_A_Z, 8191);
		query(MARK_B_X, MARK_B_Y, MARK_B_Z + 480, MARK_B_SLOT);

		// writes to undecoded indexes must leave every register alone
		configure(CFG_DATA_W'(CLUSTER_SLOTS), 480, 480, 0, 0);
		for (int idx = CFG_SPARE_FIRST; idx <= CFG_SPARE_LAST; idx++)
			write_reg(CFG_IDX_W'(idx), 16'hFFFF);
		query(3000, -2000, 3000, 0);

		// random epochs over the cluster
		for (int e = 0; e < EPOCHS; e++) begin
			if ($urandom_range(0, 9) == 0)
				count = 0;
			else
				count = $urandom_range(1, CLUSTER_SLOTS);
			configure(CFG_DATA_W'(count), draw_radius(), draw_radius(), draw_pit_bound(),
				draw_pit_bound());
			steady = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < EPOCH_WORDS; k++)
				random_word();
			steady = 1'b0;
		end

		// drain and give the verdict
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("track_point_radius_search_unit test passed");
		else
			$display("track_point_radius_search_unit test failed");
		$finish;
	end

endmodule

// File: filelist.f
hdl/tprs_pkg.sv
hdl/tprs_ram.sv
hdl/tprs_ctrl.sv
hdl/tprs_dp.sv
hdl/track_point_radius_search_unit.sv
test/tprs_match_checker.sv
test/testbench.sv
